// ===== rtl/adcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AD-Census matching cost package
// Request types, register indexes and cost constants shared by the block.
// ----------------------------------------------------------------------------
package adcm_pkg;

	localparam int MAX_DISPARITY_DEF = 64;
	localparam int MAX_WIDTH_DEF     = 4096;

	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_INDEX_BITS = 2;
	localparam int WIDTH_BITS     = 13;
	localparam int HEIGHT_BITS    = 13;
	localparam int DISP_BITS      = 6;
	localparam int ROW_BITS       = 12;
	localparam int ROW_LIMIT      = 4096;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [DISP_BITS-1:0]   DISP_RESET   = 6'd0;

	localparam logic [4:0] TRUNC_LIMIT   = 5'd20;
	localparam logic [2:0] GRAY_WEIGHT   = 3'd6;
	localparam logic [3:0] CENSUS_WEIGHT = 4'd15;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_DISPARITY    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] left_gray;
		logic [7:0] right_gray;
		logic [7:0] left_census;
		logic [7:0] right_census;
	} pixel_t;

	typedef struct packed {
		logic [7:0] match_cost;
		logic       row_end;
		logic       frame_end;
	} cost_t;

endpackage
`default_nettype wire

// ===== rtl/ad_census_matching_cost.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AD-Census matching cost
// Truncated gray difference plus weighted census Hamming distance for one
// disparity, with row and frame end flags, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while the output is not stalled and
// passes each cost through the stage 1 registers and then the output register; the
// rate is set by the history memory, which has one write and one read port and is
// written and read once for each pixel. The history memory of
// MAX_DISPARITY entries is not cleared after reset, and no clearing pass is
// needed because only pixels of the current row are read back. Configuration
// writes are always accepted and should be made only while no pixel is in flight.
module ad_census_matching_cost #(
	parameter int MAX_DISPARITY = adcm_pkg::MAX_DISPARITY_DEF,
	parameter int MAX_WIDTH     = adcm_pkg::MAX_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 pixel_valid,
	output logic                                pixel_stall,
	input  wire adcm_pkg::pixel_t               pixel,
	output logic                                cost_valid,
	input  wire                                 cost_stall,
	output adcm_pkg::cost_t                     cost,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [adcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire [adcm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import adcm_pkg::*;

	localparam int PW = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > WIDTH_BITS) ? CW + 1 : WIDTH_BITS;
	localparam int DW = (PW > DISP_BITS) ? PW : DISP_BITS;
	localparam int LW = (CW > DW) ? CW : DW;

	// Configuration registers
	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [DISP_BITS-1:0]   disp_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			disp_q   <= DISP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				REG_DISPARITY:    disp_q   <= cfg_data[DISP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Handshake and pipeline control
	logic valid_s1;
	logic out_load;
	logic s1_adv;
	logic pix_acc;

	assign out_load    = !cost_valid || !cost_stall;
	assign s1_adv      = valid_s1 && out_load;
	assign pixel_stall = valid_s1 && !out_load;
	assign pix_acc     = pixel_valid && !pixel_stall;

	// Position state
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [PW-1:0]       ptr_q;
	logic [15:0]         first_q;

	// Effective limits after saturation
	logic [EW-1:0]          width_eff;
	logic [HEIGHT_BITS-1:0] height_eff;
	logic [DW-1:0]          disp_eff;
	logic [PW-1:0]          disp_ptr;

	always_comb begin
		width_eff = EW'(width_q);
		if (width_eff == '0) begin
			width_eff = EW'(1);
		end else if (width_eff > EW'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end
		height_eff = height_q;
		if (height_eff == '0) begin
			height_eff = HEIGHT_BITS'(1);
		end else if (height_eff > HEIGHT_BITS'(ROW_LIMIT)) begin
			height_eff = HEIGHT_BITS'(ROW_LIMIT);
		end
		disp_eff = DW'(disp_q);
		if (disp_eff > DW'(MAX_DISPARITY - 1)) begin
			disp_eff = DW'(MAX_DISPARITY - 1);
		end
	end

	assign disp_ptr = disp_eff[PW-1:0];

	logic [15:0]         cur;
	logic [15:0]         first_now;
	logic [EW-1:0]       col_inc;
	logic [ROW_BITS:0]   row_inc;
	logic                row_end_now;
	logic                frame_end_now;
	logic                use_first;
	logic                use_cur;
	logic [PW-1:0]       rd_addr;
	logic [PW-1:0]       ptr_next;

	assign cur           = {pixel.left_gray, pixel.left_census};
	assign first_now     = (col_q == '0) ? cur : first_q;
	assign col_inc       = EW'(col_q) + EW'(1);
	assign row_inc       = (ROW_BITS + 1)'(row_q) + (ROW_BITS + 1)'(1);
	assign row_end_now   = col_inc >= width_eff;
	assign frame_end_now = row_end_now && (HEIGHT_BITS'(row_inc) >= height_eff);
	assign use_first     = LW'(col_q) < LW'(disp_eff);
	// With no shift the compared left pixel is the one arriving now.
	assign use_cur       = disp_eff == '0;
	assign ptr_next      = (ptr_q == PW'(MAX_DISPARITY - 1)) ? '0 : ptr_q + PW'(1);

	always_comb begin
		if (ptr_q >= disp_ptr) begin
			rd_addr = ptr_q - disp_ptr;
		end else begin
			rd_addr = PW'((PW + 1)'(ptr_q) + (PW + 1)'(MAX_DISPARITY) - (PW + 1)'(disp_ptr));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			ptr_q   <= '0;
			first_q <= '0;
		end else if (pix_acc) begin
			first_q <= first_now;
			ptr_q   <= ptr_next;
			if (row_end_now) begin
				col_q <= '0;
				row_q <= frame_end_now ? '0 : row_inc[ROW_BITS-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Ring of recent left pixels; entries are read only after being written in this row.
	logic [15:0] hist_mem [MAX_DISPARITY];
	logic [15:0] hist_rd_q;

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			hist_mem[ptr_q] <= cur;
			hist_rd_q       <= hist_mem[rd_addr];
		end
	end

	// Stage 1 registers
	logic [7:0]  right_gray_s1;
	logic [7:0]  right_census_s1;
	logic [15:0] cur_s1;
	logic [15:0] first_s1;
	logic        use_first_s1;
	logic        use_cur_s1;
	logic        row_end_s1;
	logic        frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			right_gray_s1   <= pixel.right_gray;
			right_census_s1 <= pixel.right_census;
			cur_s1          <= cur;
			first_s1        <= first_now;
			use_first_s1    <= use_first;
			use_cur_s1      <= use_cur;
			row_end_s1      <= row_end_now;
			frame_end_s1    <= frame_end_now;
		end
	end

	// Cost arithmetic
	logic [15:0] left_sel;
	logic [7:0]  gray_diff;
	logic [4:0]  gray_trunc;
	logic [7:0]  census_xor;
	logic [3:0]  ham;
	logic [7:0]  cost_now;

	always_comb begin
		priority if (use_first_s1) begin
			left_sel = first_s1;
		end else if (use_cur_s1) begin
			left_sel = cur_s1;
		end else begin
			left_sel = hist_rd_q;
		end
		gray_diff = (right_gray_s1 > left_sel[15:8]) ? right_gray_s1 - left_sel[15:8]
			: left_sel[15:8] - right_gray_s1;
		gray_trunc = (gray_diff > 8'(TRUNC_LIMIT)) ? TRUNC_LIMIT : gray_diff[4:0];
		census_xor = left_sel[7:0] ^ right_census_s1;
		ham = '0;
		for (int i = 0; i < 8; i++) begin
			ham = ham + 4'(census_xor[i]);
		end
		cost_now = 8'(gray_trunc) * 8'(GRAY_WEIGHT) + 8'(ham) * 8'(CENSUS_WEIGHT);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_valid <= 1'b0;
		end else if (out_load) begin
			cost_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cost.match_cost <= cost_now;
			cost.row_end    <= row_end_s1;
			cost.frame_end  <= frame_end_s1;
		end
	end

endmodule
`default_nettype wire
